@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fdpl_pkg.sv @@
`default_nettype none

package fdpl_pkg;

    localparam int STORE_DEPTH = 524288;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CHANNEL_W   = 8;
    localparam int PIXEL_W     = 3 * CHANNEL_W;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 10;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 9;
    localparam int SUM_W       = 10;
    localparam int SIZE_W      = 20;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_STORE   = 1'b0;
    localparam logic CMD_COMPARE = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd480;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = 10'd512;

    typedef struct packed {
        logic                 cmd;
        logic [CHANNEL_W-1:0] red;
        logic [CHANNEL_W-1:0] green;
        logic [CHANNEL_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] diff_red;
        logic [CHANNEL_W-1:0] diff_green;
        logic [CHANNEL_W-1:0] diff_blue;
        logic                 frame_done;
        logic [COL_W-1:0]     peak_x;
        logic [ROW_W-1:0]     peak_y;
        logic [SUM_W-1:0]     peak_diff;
    } result_t;

    function automatic logic [CHANNEL_W-1:0] abs_diff(
        input logic [CHANNEL_W-1:0] a,
        input logic [CHANNEL_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

@@ rtl/fdpl_if.sv @@
`default_nettype none

interface fdpl_pix_if import fdpl_pkg::*;;
    logic   valid;
    logic   ready;
    pixel_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fdpl_res_if import fdpl_pkg::*;;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/fdpl_ram.sv @@
`default_nettype none

module fdpl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/frame_difference_peak_locator.sv @@
// Frame-difference motion peak locator. Store words (cmd 0) write one
// reference pixel into a 512K x 24 frame memory in raster order and give no
// result; compare words (cmd 1) read the reference pixel at the running
// compare position and give one result word with the per-channel absolute
// differences, plus the frame peak on the last pixel of the frame. The block
// accepts one word per clock unless the input stalls: a store is one memory
// write and a compare one memory read. The memory read happens at the edge
// that accepts a compare; the result word is registered in the output register
// when the compare stage advances and is held while res.ready is low. Input
// stalls only when both the compare stage and the output register are full and
// res.ready is low. A geometry register write applies to the next word.
`default_nettype none
`include "assert_macros.svh"

module frame_difference_peak_locator import fdpl_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    fdpl_pix_if.sink                    pix,
    fdpl_res_if.source                  res,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [ADDR_W-1:0]   load_index_reg;
    logic [ADDR_W-1:0]   compare_index_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [SUM_W-1:0]    best_sum_reg;
    logic [COL_W-1:0]    best_col_reg;
    logic [ROW_W-1:0]    best_row_reg;

    logic                 s1_valid_reg;
    logic [CHANNEL_W-1:0] s1_red_reg;
    logic [CHANNEL_W-1:0] s1_green_reg;
    logic [CHANNEL_W-1:0] s1_blue_reg;
    logic [COL_W-1:0]     s1_col_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic                 s1_last_reg;

    logic    out_valid_reg;
    result_t out_reg;

    pixel_t             word;
    logic               accept;
    logic               s1_adv;
    logic               last_col;
    logic               last_row;
    logic [PIXEL_W-1:0] ref_pixel;
    logic [WIDTH_W-1:0] width_next;
    logic [HEIGHT_W-1:0] height_next;
    logic [SIZE_W-1:0]  frame_size;
    logic [SIZE_W-1:0]  load_next;
    logic [CHANNEL_W-1:0] d_red;
    logic [CHANNEL_W-1:0] d_green;
    logic [CHANNEL_W-1:0] d_blue;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   best_sum_next;
    logic [COL_W-1:0]   best_col_next;
    logic [ROW_W-1:0]   best_row_next;

    assign word      = pix.data;
    assign s1_adv    = !out_valid_reg || res.ready;
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign accept    = pix.valid && pix.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    always_comb
    begin
        width_next = cfg_data;
        if (width_next == '0)
        begin
            width_next = WIDTH_W'(1);
        end
        else if (width_next > WIDTH_MAX)
        begin
            width_next = WIDTH_MAX;
        end
        height_next = cfg_data[HEIGHT_W-1:0];
        if (height_next == '0)
        begin
            height_next = HEIGHT_W'(1);
        end
        else if (height_next > HEIGHT_MAX)
        begin
            height_next = HEIGHT_MAX;
        end
    end

    assign frame_size = SIZE_W'(width_reg) * SIZE_W'(height_reg);
    assign load_next  = SIZE_W'(load_index_reg) + SIZE_W'(1);
    assign last_col   = (WIDTH_W'(col_reg) + WIDTH_W'(1)) >= width_reg;
    assign last_row   = (HEIGHT_W'(row_reg) + HEIGHT_W'(1)) >= height_reg;

    fdpl_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (accept && (word.cmd == CMD_STORE)),
        .waddr (load_index_reg),
        .wdata ({word.red, word.green, word.blue}),
        .re    (accept && (word.cmd == CMD_COMPARE)),
        .raddr (compare_index_reg),
        .rdata (ref_pixel)
    );

    always_comb
    begin
        d_red   = abs_diff(s1_red_reg, ref_pixel[3*CHANNEL_W-1:2*CHANNEL_W]);
        d_green = abs_diff(s1_green_reg, ref_pixel[2*CHANNEL_W-1:CHANNEL_W]);
        d_blue  = abs_diff(s1_blue_reg, ref_pixel[CHANNEL_W-1:0]);
        sum     = SUM_W'(d_red) + SUM_W'(d_green) + SUM_W'(d_blue);
        if (sum > best_sum_reg)
        begin
            best_sum_next = sum;
            best_col_next = s1_col_reg;
            best_row_next = s1_row_reg;
        end
        else
        begin
            best_sum_next = best_sum_reg;
            best_col_next = best_col_reg;
            best_row_next = best_row_reg;
        end
    end

    // geometry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_FRAME_WIDTH))
            begin
                width_reg <= width_next;
            end
            if (cfg_we && (cfg_index == REG_FRAME_HEIGHT))
            begin
                height_reg <= height_next;
            end
        end
    end

    // positions and first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg    <= '0;
            compare_index_reg <= '0;
            col_reg           <= '0;
            row_reg           <= '0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (pix.ready)
            begin
                s1_valid_reg <= accept && (word.cmd == CMD_COMPARE);
            end
            if (accept && (word.cmd == CMD_STORE))
            begin
                if (load_next >= frame_size)
                begin
                    load_index_reg <= '0;
                end
                else
                begin
                    load_index_reg <= load_next[ADDR_W-1:0];
                end
            end
            if (accept && (word.cmd == CMD_COMPARE))
            begin
                if (last_col && last_row)
                begin
                    compare_index_reg <= '0;
                    col_reg           <= '0;
                    row_reg           <= '0;
                end
                else
                begin
                    compare_index_reg <= compare_index_reg + ADDR_W'(1);
                    if (last_col)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (word.cmd == CMD_COMPARE))
        begin
            s1_red_reg   <= word.red;
            s1_green_reg <= word.green;
            s1_blue_reg  <= word.blue;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_last_reg  <= last_col && last_row;
        end
    end

    // peak tracker and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg  <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    best_sum_reg <= '0;
                    best_col_reg <= '0;
                    best_row_reg <= '0;
                end
                else
                begin
                    best_sum_reg <= best_sum_next;
                    best_col_reg <= best_col_next;
                    best_row_reg <= best_row_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_reg.diff_red   <= d_red;
            out_reg.diff_green <= d_green;
            out_reg.diff_blue  <= d_blue;
            out_reg.frame_done <= s1_last_reg;
            out_reg.peak_x     <= s1_last_reg ? best_col_next : '0;
            out_reg.peak_y     <= s1_last_reg ? best_row_next : '0;
            out_reg.peak_diff  <= s1_last_reg ? best_sum_next : '0;
        end
    end

    `ASSERT_NOW(a_stall_means_full, clk, rst_n, !pix.ready, s1_valid_reg && out_valid_reg)
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg)
    `ASSERT_NOW(a_peak_only_at_end, clk, rst_n, out_valid_reg && !out_reg.frame_done,
        (out_reg.peak_x == '0) && (out_reg.peak_y == '0) && (out_reg.peak_diff == '0))

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fdpl_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int MODE_SAME   = 0;
    localparam int MODE_JITTER = 1;
    localparam int MODE_WILD   = 2;
    localparam int FILL_DEPTH  = 64;
    localparam int MAX_SIDE    = 6;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fdpl_pix_if pix_if ();
    fdpl_res_if res_if ();

    frame_difference_peak_locator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // geometry, positions and peak tracker as the block should hold them
    int frame_w = int'(WIDTH_RESET);
    int frame_h = int'(HEIGHT_RESET);
    int load_pos = 0;
    int cmp_pos = 0;
    int cmp_col = 0;
    int cmp_row = 0;
    int best_sum = 0;
    int best_col = 0;
    int best_row = 0;
    bit frame_closed = 1'b0;
    logic [PIXEL_W-1:0] stored [int];
    result_t pending_diffs [$];

    int mismatch_count = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    always #1 clk = ~clk;

    function automatic logic [CHANNEL_W-1:0] channel_gap(
        input logic [CHANNEL_W-1:0] a,
        input logic [CHANNEL_W-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit at_frame_end();
        return (cmp_col + 1 >= frame_w) && (cmp_row + 1 >= frame_h);
    endfunction

    function automatic void apply_geometry(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        int v;
        if (index == REG_FRAME_WIDTH)
        begin
            v = int'(data[WIDTH_W-1:0]);
            frame_w = (v < 1) ? 1 : (v > int'(WIDTH_MAX)) ? int'(WIDTH_MAX) : v;
        end
        else
        begin
            v = int'(data[HEIGHT_W-1:0]);
            frame_h = (v < 1) ? 1 : (v > int'(HEIGHT_MAX)) ? int'(HEIGHT_MAX) : v;
        end
    endfunction

    function automatic void track_pixel(input pixel_t px);
        logic [PIXEL_W-1:0] refpx;
        result_t r;
        int sum;
        bit last_col;
        bit last_row;
        if (px.cmd == CMD_STORE)
        begin
            stored[load_pos % STORE_DEPTH] = {px.red, px.green, px.blue};
            load_pos = (load_pos + 1 >= frame_w * frame_h) ? 0 : load_pos + 1;
            return;
        end
        refpx = stored.exists(cmp_pos % STORE_DEPTH) ? stored[cmp_pos % STORE_DEPTH] : '0;
        r = '0;
        r.diff_red   = channel_gap(px.red, refpx[23:16]);
        r.diff_green = channel_gap(px.green, refpx[15:8]);
        r.diff_blue  = channel_gap(px.blue, refpx[7:0]);
        sum = int'(r.diff_red) + int'(r.diff_green) + int'(r.diff_blue);
        last_col = cmp_col + 1 >= frame_w;
        last_row = cmp_row + 1 >= frame_h;
        if (sum > best_sum)
        begin
            best_sum = sum;
            best_col = cmp_col;
            best_row = cmp_row;
        end
        if (last_col && last_row)
        begin
            r.frame_done = 1'b1;
            r.peak_x     = COL_W'(best_col);
            r.peak_y     = ROW_W'(best_row);
            r.peak_diff  = SUM_W'(best_sum);
            cmp_col = 0;
            cmp_row = 0;
            cmp_pos = 0;
            best_sum = 0;
            best_col = 0;
            best_row = 0;
            frame_closed = 1'b1;
        end
        else
        begin
            cmp_pos = (cmp_pos + 1) & 'h7FFFF;
            if (last_col)
            begin
                cmp_col = 0;
                cmp_row = (cmp_row + 1) & 'h1FF;
            end
            else
                cmp_col = (cmp_col + 1) & 'h3FF;
        end
        pending_diffs.push_back(r);
    endfunction

    function automatic pixel_t compare_pixel(input int mode);
        logic [PIXEL_W-1:0] base;
        pixel_t px;
        base = stored.exists(cmp_pos % STORE_DEPTH) ? stored[cmp_pos % STORE_DEPTH] : '0;
        px.cmd = CMD_COMPARE;
        if (mode == MODE_SAME)
            {px.red, px.green, px.blue} = base;
        else if (mode == MODE_JITTER)
            {px.red, px.green, px.blue} = base ^ {6'd0, 2'($urandom), 6'd0, 2'($urandom),
                                                  6'd0, 2'($urandom)};
        else
            {px.red, px.green, px.blue} = PIXEL_W'($urandom);
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= px;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        track_pixel(px);
        items_sent++;
    endtask

    task automatic send_rgb(input logic cmd, input int r, input int g, input int b);
        pixel_t px;
        px.cmd   = cmd;
        px.red   = CHANNEL_W'(r);
        px.green = CHANNEL_W'(g);
        px.blue  = CHANNEL_W'(b);
        send_pixel(px);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (pending_diffs.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_geometry(input int wdata, input int hdata);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(wdata);
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(hdata);
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_geometry(REG_FRAME_WIDTH, CFG_DATA_W'(wdata));
        apply_geometry(REG_FRAME_HEIGHT, CFG_DATA_W'(hdata));
        repeat (2) @(negedge clk);
    endtask

    task automatic load_frame(input int n);
        repeat (n)
            send_rgb(CMD_STORE, $urandom_range(255), $urandom_range(255), $urandom_range(255));
    endtask

    task automatic compare_frame(input int mode, input bit spike_last);
        pixel_t px;
        frame_closed = 1'b0;
        do
        begin
            px = compare_pixel(mode);
            if (spike_last && at_frame_end())
            begin
                px.red   ^= 8'h80;
                px.green ^= 8'h80;
                px.blue  ^= 8'h80;
            end
            send_pixel(px);
        end
        while (!frame_closed);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic test_midframe_geometry();
        load_frame(8);
        repeat (4) send_pixel(compare_pixel(MODE_WILD));
        set_geometry(2, 2);
        compare_frame(MODE_WILD, 1'b0);
    endtask

    task automatic test_channel_extremes();
        while (load_pos != 0)
            send_rgb(CMD_STORE, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        send_rgb(CMD_STORE, 0, 0, 0);
        send_rgb(CMD_STORE, 255, 255, 255);
        send_rgb(CMD_STORE, 0, 255, 0);
        send_rgb(CMD_STORE, 128, 128, 128);
        send_rgb(CMD_COMPARE, 255, 255, 255);
        send_rgb(CMD_COMPARE, 0, 0, 0);
        send_rgb(CMD_COMPARE, 0, 255, 0);
        send_rgb(CMD_COMPARE, 127, 129, 128);
    endtask

    task automatic test_no_motion();
        compare_frame(MODE_SAME, 1'b0);
    endtask

    task automatic test_geometry_limits();
        set_geometry(11'h7FF, 11'h7FF);
        repeat (3) send_pixel(compare_pixel(MODE_JITTER));
        set_geometry(0, 0);
        compare_frame(MODE_WILD, 1'b1);
        load_frame(1);
        set_geometry(1, 1536);
        repeat (3) send_pixel(compare_pixel(MODE_JITTER));
        set_geometry(2, 2);
        compare_frame(MODE_JITTER, 1'b1);
    endtask

    task automatic fill_reference();
        set_geometry(8, FILL_DEPTH / 8);
        while (load_pos != 0)
            send_rgb(CMD_STORE, $urandom_range(255), $urandom_range(255), $urandom_range(255));
        load_frame(FILL_DEPTH);
    endtask

    task automatic random_traffic(input int count);
        int target;
        int w;
        int h;
        target = items_sent + count;
        while (items_sent < target)
        begin
            w = $urandom_range(1, MAX_SIDE);
            h = $urandom_range(1, MAX_SIDE);
            // keep compares inside the region already loaded
            if (cmp_pos + MAX_SIDE * MAX_SIDE > FILL_DEPTH)
            begin
                w = 1;
                h = 1;
            end
            set_geometry(w, h);
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(99) < 70)
                begin
                    load_frame(frame_w * frame_h);
                    compare_frame($urandom_range(MODE_SAME, MODE_WILD), 1'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        if ($urandom_range(1) == 1 && stored.exists(cmp_pos % STORE_DEPTH))
                            send_pixel(compare_pixel(MODE_WILD));
                        else
                            send_rgb(CMD_STORE, $urandom_range(255), $urandom_range(255),
                                     $urandom_range(255));
                    end
                end
            end
        end
    endtask

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        begin
            got = res_if.data;
            if (pending_diffs.size() == 0)
                report_mismatch("unexpected word, frame_done", got.frame_done, 0);
            else
            begin
                want = pending_diffs.pop_front();
                if (got.diff_red !== want.diff_red)
                    report_mismatch("diff_red", got.diff_red, want.diff_red);
                if (got.diff_green !== want.diff_green)
                    report_mismatch("diff_green", got.diff_green, want.diff_green);
                if (got.diff_blue !== want.diff_blue)
                    report_mismatch("diff_blue", got.diff_blue, want.diff_blue);
                if (got.frame_done !== want.frame_done)
                    report_mismatch("frame_done", got.frame_done, want.frame_done);
                if (got.peak_x !== want.peak_x)
                    report_mismatch("peak_x", got.peak_x, want.peak_x);
                if (got.peak_y !== want.peak_y)
                    report_mismatch("peak_y", got.peak_y, want.peak_y);
                if (got.peak_diff !== want.peak_diff)
                    report_mismatch("peak_diff", got.peak_diff, want.peak_diff);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_if.valid === 1'b1 && pix_if.ready === 1'b1)
            || (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_FRAME_WIDTH;
        cfg_data     = '0;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 27;
        stall_pct     = 76;
        test_midframe_geometry();
        test_channel_extremes();
        test_no_motion();
        test_geometry_limits();
        fill_reference();
        random_traffic(140);

        send_idle_pct = 76;
        stall_pct     = 27;
        random_traffic(140);

        send_idle_pct = 0;
        stall_pct     = 0;
        random_traffic(140);

        wait_quiet();
        repeat (8) @(negedge clk);
        for (int i = 0; i < pending_diffs.size(); i++)
            report_mismatch("missing word, frame_done", -1, pending_diffs[i].frame_done);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
